@@ hw/rtl/rfifo_pkg.sv @@
// Shared constants and types for the ring FIFO with drop count.
`default_nettype none

package rfifo_pkg;

  // Storage geometry
  localparam int DEPTH      = 64;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int DATA_W     = 64;
  localparam int CAP_LOG2_W = 3;
  localparam int DROP_W     = 16;

  // Result packing: ok, read_data, entry_count, is_empty, is_full, drop_total
  localparam int OUT_BITS   = 1 + DATA_W + PTR_W + 1 + 1 + DROP_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Reset capacity: log2 of the storage depth
  localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RST = CAP_LOG2_W'(SLOT_W);

  // Operation codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_PEEK  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // perform the operation and load the result register
  } rfifo_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/rfifo_ctrl.sv @@
// Controller state machine for the ring FIFO: handshakes and sequencing.
`default_nettype none

module rfifo_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output rfifo_pkg::rfifo_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Take an item only when no operation is in flight
  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = in_tvalid && in_tready;
  // Execute once the result register is free or being drained
  assign cmd.exec    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid  = out_valid_r;

  // Advance state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rfifo_dp.sv @@
// Datapath for the ring FIFO: entry memory, pointers, drop counter, result register.
`default_nettype none

module rfifo_dp (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  rfifo_pkg::rfifo_cmd_t                  cmd,
  input  wire  [1:0]                             in_action,
  input  wire  [rfifo_pkg::DATA_W-1:0]           in_push_data,
  input  wire                                    cfg_we,
  input  wire  [rfifo_pkg::CAP_LOG2_W-1:0]       cfg_cap_log2,
  output logic [rfifo_pkg::OUT_TDATA_W-1:0]      out_data
);

  localparam int SW = rfifo_pkg::SLOT_W;
  localparam int PW = rfifo_pkg::PTR_W;
  localparam int DW = rfifo_pkg::DATA_W;

  // Entry storage
  logic [DW-1:0] mem [rfifo_pkg::DEPTH];

  logic [rfifo_pkg::CAP_LOG2_W-1:0] cap_log2_r;
  logic [PW-1:0]                    wp_r, wp_nxt;
  logic [PW-1:0]                    rp_r, rp_nxt;
  logic [rfifo_pkg::DROP_W-1:0]     drop_r, drop_nxt;
  logic [1:0]                       act_r;
  logic [DW-1:0]                    data_r;
  logic [DW-1:0]                    rd_data_r;
  logic [rfifo_pkg::OUT_TDATA_W-1:0] out_r;

  logic [PW-1:0] cap;
  logic [SW-1:0] slot_mask;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] wr_slot;
  logic [PW-1:0] count;
  logic [PW-1:0] count_nxt;
  logic          at_cap;
  logic          wr_en;
  logic          ok;
  logic [DW-1:0] rd_val;

  // Usable capacity, saturated to the storage depth
  always_comb begin
    if (cap_log2_r >= rfifo_pkg::CAP_LOG2_W'(SW)) begin
      cap = PW'(rfifo_pkg::DEPTH);
    end else begin
      cap = PW'(1) << cap_log2_r;
    end
  end

  assign slot_mask = SW'(cap - PW'(1));
  assign rd_slot   = rp_r[SW-1:0] & slot_mask;
  assign wr_slot   = wp_r[SW-1:0] & slot_mask;
  assign count     = wp_r - rp_r;
  assign at_cap    = (count >= cap);

  // Decode the operation
  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    drop_nxt = drop_r;
    wr_en    = 1'b0;
    ok       = 1'b0;
    rd_val   = '0;
    case (act_r)
      rfifo_pkg::ACT_PUSH: begin
        if (at_cap) begin
          drop_nxt = drop_r + 1'b1;
        end else begin
          wr_en  = 1'b1;
          wp_nxt = wp_r + 1'b1;
          ok     = 1'b1;
        end
      end
      rfifo_pkg::ACT_POP, rfifo_pkg::ACT_PEEK: begin
        if (count != '0) begin
          rd_val = rd_data_r;
          ok     = 1'b1;
          if (act_r == rfifo_pkg::ACT_POP) rp_nxt = rp_r + 1'b1;
        end
      end
      rfifo_pkg::ACT_CLEAR: begin
        rp_nxt = wp_r;
        ok     = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign count_nxt = wp_nxt - rp_nxt;

  // Memory: write on a stored push, read the head slot every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_slot] <= data_r;
    end
    rd_data_r <= mem[rd_slot];
  end

  // Control state: pointers, drop counter, capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      drop_r     <= '0;
      cap_log2_r <= rfifo_pkg::CAP_LOG2_RST;
    end else begin
      if (cmd.exec) begin
        wp_r   <= wp_nxt;
        rp_r   <= rp_nxt;
        drop_r <= drop_nxt;
      end
      if (cfg_we) cap_log2_r <= cfg_cap_log2;
    end
  end

  // Latch the item and load the result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      data_r <= in_push_data;
    end
    if (cmd.exec) begin
      out_r <= rfifo_pkg::OUT_TDATA_W'({drop_nxt,
                                        (count_nxt >= cap),
                                        (count_nxt == '0),
                                        count_nxt,
                                        rd_val,
                                        ok});
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ hw/rtl/ring_fifo_with_drop_count.sv @@
// Top level of the ring FIFO with drop count: controller plus datapath.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser: action; tdata: push_data
//  out_     out  out_tvalid/out_tready  tdata: ok, read_data, entry_count,
//                                              is_empty, is_full, drop_total
//  cfg_     in   cfg_valid/cfg_ready    cfg_data: capacity_log2
//
// Each item passes two controller states: idle latches it while the entry
// memory's head slot is read into a register; execute works on that data.
// A stalled result holds in the output register and the item after it waits
// in execute until the result is taken. Reset clears pointers and the drop
// counter and sets capacity to the full depth; no clearing pass is needed.
`default_nettype none

module ring_fifo_with_drop_count (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [rfifo_pkg::DATA_W-1:0]       in_tdata,   // [63:0] push_data
  input  wire  [1:0]                         in_tuser,   // [1:0] action
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [0] ok, [64:1] read_data, [71:65] entry_count, [72] is_empty,
  // [73] is_full, [89:74] drop_total, [95:90] zero
  output logic [rfifo_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [rfifo_pkg::CAP_LOG2_W-1:0]   cfg_data    // [2:0] capacity_log2
);

  rfifo_pkg::rfifo_cmd_t cmd;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  rfifo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rfifo_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_action    (in_tuser),
    .in_push_data (in_tdata),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_cap_log2 (cfg_data),
    .out_data     (out_tdata)
  );

endmodule

`default_nettype wire
